>>> rtl/pfvp_pkg.sv
// Shared types, codes and constant tables for the performance-state decoder.
`default_nettype none

package pfvp_pkg;

	// Result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_DFS    = 2'd1;
	localparam logic [1:0] ST_BAD_IDDDIV = 2'd2;

	// Current scale codes
	localparam logic [1:0] IDD_DIV_100   = 2'd0;
	localparam logic [1:0] IDD_DIV_1000  = 2'd1;
	localparam logic [1:0] IDD_DIV_10000 = 2'd2;
	localparam logic [1:0] IDD_DIV_BAD   = 2'd3;

	// Divisor id limits
	localparam logic [5:0] DFS_DIV_MIN   = 6'd8;    // also used as divide-by-one (8 eighths)
	localparam logic [5:0] DFS_DIV_MAX   = 6'h2C;
	localparam logic [5:0] DFS_ODD_LIMIT = 6'h1A;

	// Voltage: 250 mV + 5 mV * (id - 1) == 245 mV + 5 mV * id
	localparam logic [20:0] VOLT_OFFSET_UV = 21'd245000;
	localparam logic [20:0] VOLT_STEP_UV   = 21'd5000;

	// volt/10 == 500 * (id + 49), so power reduces to a product m = (id + 49) * idd
	localparam logic [8:0] PWR_VID_OFFSET = 9'd49;

	// floor(2^18 / 5) + 1, exact x/5 for 15-bit x
	localparam logic [30:0] RECIP_5   = 31'd52429;
	localparam int          RECIP_5_SH = 18;

	// Reciprocal shift for the frequency divider
	localparam int RECIP_SH = 20;

	// Per-stage load enables from the pipeline control
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_ld_t;

	// floor(2^20 / d) for the divisor ids in use
	function automatic logic [17:0] dfs_recip(input logic [5:0] d);
		logic [17:0] r;
		unique case (d)
			6'd8:    r = 18'd131072;
			6'd9:    r = 18'd116508;
			6'd10:   r = 18'd104857;
			6'd11:   r = 18'd95325;
			6'd12:   r = 18'd87381;
			6'd13:   r = 18'd80659;
			6'd14:   r = 18'd74898;
			6'd15:   r = 18'd69905;
			6'd16:   r = 18'd65536;
			6'd17:   r = 18'd61680;
			6'd18:   r = 18'd58254;
			6'd19:   r = 18'd55188;
			6'd20:   r = 18'd52428;
			6'd21:   r = 18'd49932;
			6'd22:   r = 18'd47662;
			6'd23:   r = 18'd45590;
			6'd24:   r = 18'd43690;
			6'd25:   r = 18'd41943;
			6'd26:   r = 18'd40329;
			6'd27:   r = 18'd38836;
			6'd28:   r = 18'd37449;
			6'd29:   r = 18'd36157;
			6'd30:   r = 18'd34952;
			6'd31:   r = 18'd33825;
			6'd32:   r = 18'd32768;
			6'd33:   r = 18'd31775;
			6'd34:   r = 18'd30840;
			6'd35:   r = 18'd29959;
			6'd36:   r = 18'd29127;
			6'd37:   r = 18'd28339;
			6'd38:   r = 18'd27594;
			6'd39:   r = 18'd26886;
			6'd40:   r = 18'd26214;
			6'd41:   r = 18'd25575;
			6'd42:   r = 18'd24966;
			6'd43:   r = 18'd24385;
			6'd44:   r = 18'd23831;
			default: r = 18'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/pstate_freq_volt_power_decode.sv
// Top level of the performance-state decoder: pipeline control, status and the two data paths.
//
// Usage:
//  - Input channel in_valid/in_stall carries one performance-state definition per
//    transaction; the output channel out_valid/out_stall carries one decoded result
//    (tag, status, valid flag, MHz, microvolts, milliwatts) per input transaction.
//  - Four register stages (s1 to s4): a result is presented from s4 once its input
//    transaction has passed through s1, s2 and s3, and stays until taken.
//  - Throughput is one transaction per cycle while out_stall is low; the frequency divider
//    (reciprocal multiply, back-multiply, correction) sets the depth of four stages.
//  - Each stage moves forward whenever the stage after it is empty or moving, so
//    bubbles close up under a stalled receiver and new input is still taken while a
//    result waits; in_stall rises only when all four stages hold results.
//  - Results leave in input order; there is no state between transactions.
//  - Reset clears all stage valid bits, leaving the block ready for input.
`default_nettype none

module pstate_freq_volt_power_decode (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  pstate_number,
	input  wire logic        state_enabled,
	input  wire logic [11:0] core_fid,
	input  wire logic [5:0]  dfs_id,
	input  wire logic [7:0]  voltage_id,
	input  wire logic [7:0]  idd_value,
	input  wire logic [1:0]  idd_divider,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       pstate_tag,
	output logic [1:0]       status,
	output logic             state_valid,
	output logic [16:0]      frequency_mhz,
	output logic [20:0]      voltage_uv,
	output logic [18:0]      power_mw
);
	import pfvp_pkg::*;

	stage_ld_t ld;
	logic      v_s1, v_s2, v_s3, v_s4;
	logic      bad_dfs, bad_div, keep_fv, keep_p;
	logic [1:0] status_d;

	logic [2:0] tag_s1, tag_s2, tag_s3, tag_s4;
	logic [1:0] st_s1, st_s2, st_s3, st_s4;
	logic       ok_s1, ok_s2, ok_s3, ok_s4;

	// Ready chain: a stage loads when it is empty or its content moves on
	assign ld.s4    = !v_s4 || !out_stall;
	assign ld.s3    = !v_s3 || ld.s4;
	assign ld.s2    = !v_s2 || ld.s3;
	assign ld.s1    = !v_s1 || ld.s2;
	assign in_stall = !ld.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld.s1) v_s1 <= in_valid;
			if (ld.s2) v_s2 <= v_s1;
			if (ld.s3) v_s3 <= v_s2;
			if (ld.s4) v_s4 <= v_s3;
		end
	end

	// Status decode
	assign bad_dfs = (dfs_id > DFS_ODD_LIMIT) && dfs_id[0];
	assign bad_div = (idd_divider == IDD_DIV_BAD);
	assign keep_fv = state_enabled && !bad_dfs;
	assign keep_p  = keep_fv && !bad_div;

	always_comb begin
		if (!state_enabled) begin
			status_d = ST_OK;
		end else if (bad_dfs) begin
			status_d = ST_BAD_DFS;
		end else if (bad_div) begin
			status_d = ST_BAD_IDDDIV;
		end else begin
			status_d = ST_OK;
		end
	end

	// Tag and status travel alongside the data paths
	always_ff @(posedge clk) begin
		if (ld.s1) begin
			tag_s1 <= pstate_number;
			st_s1  <= status_d;
			ok_s1  <= keep_p;
		end
		if (ld.s2) begin
			tag_s2 <= tag_s1;
			st_s2  <= st_s1;
			ok_s2  <= ok_s1;
		end
		if (ld.s3) begin
			tag_s3 <= tag_s2;
			st_s3  <= st_s2;
			ok_s3  <= ok_s2;
		end
		if (ld.s4) begin
			tag_s4 <= tag_s3;
			st_s4  <= st_s3;
			ok_s4  <= ok_s3;
		end
	end

	pfvp_freq_div u_freq (
		.clk      (clk),
		.ld       (ld),
		.core_fid (core_fid),
		.dfs_id   (dfs_id),
		.keep     (keep_fv),
		.freq_s4  (frequency_mhz)
	);

	pfvp_volt_power u_vp (
		.clk         (clk),
		.ld          (ld),
		.voltage_id  (voltage_id),
		.idd_value   (idd_value),
		.idd_divider (idd_divider),
		.keep_volt   (keep_fv),
		.keep_pwr    (keep_p),
		.volt_s4     (voltage_uv),
		.pwr_s4      (power_mw)
	);

	assign out_valid   = v_s4;
	assign pstate_tag  = tag_s4;
	assign status      = st_s4;
	assign state_valid = ok_s4;

	// A valid state always carries ok status
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && state_valid) |-> (status == ST_OK))
		else $error("valid state with non-ok status");

	// Any abort zeroes the power
	a_abort_pwr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (power_mw == 19'd0))
		else $error("aborted result with non-zero power");

	// A bad divisor id zeroes frequency and voltage as well
	a_bad_dfs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_BAD_DFS)) |->
		((frequency_mhz == 17'd0) && (voltage_uv == 21'd0)))
		else $error("bad divisor id result with non-zero fields");

	// An empty output stage never holds the input back
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output stage");

endmodule

`default_nettype wire

>>> rtl/pfvp_freq_div.sv
// Frequency path: 200*fid/did by reciprocal multiply with one-step correction.
`default_nettype none

module pfvp_freq_div (
	input  wire logic              clk,
	input  wire pfvp_pkg::stage_ld_t ld,
	input  wire logic [11:0]       core_fid,
	input  wire logic [5:0]        dfs_id,
	input  wire logic              keep,
	output logic [16:0]            freq_s4
);
	import pfvp_pkg::*;

	logic        in_range;
	logic [5:0]  d_eff;
	logic [19:0] n_d;
	logic [37:0] prod;
	logic [22:0] qd;
	logic [19:0] rem;

	logic [19:0] n_s1, n_s2, n_s3;
	logic [5:0]  d_s1, d_s2, d_s3;
	logic [17:0] r_s1;
	logic        z_s1, z_s2, z_s3;
	logic [16:0] q_s2, q_s3;
	logic [22:0] qd_s3;

	// Stage 1: numerator, effective divisor (8 eighths outside the range) and reciprocal
	assign in_range = (dfs_id >= DFS_DIV_MIN) && (dfs_id <= DFS_DIV_MAX);
	assign d_eff    = in_range ? dfs_id : DFS_DIV_MIN;
	assign n_d      = ({8'd0, core_fid} << 7) + ({8'd0, core_fid} << 6) + ({8'd0, core_fid} << 3);

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			n_s1 <= n_d;
			d_s1 <= d_eff;
			r_s1 <= dfs_recip(d_eff);
			z_s1 <= !keep || (dfs_id == 6'd0);
		end
	end

	// Stage 2: quotient estimate, at most one below the true quotient
	assign prod = {18'd0, n_s1} * {20'd0, r_s1};

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			q_s2 <= prod[RECIP_SH+16:RECIP_SH];
			n_s2 <= n_s1;
			d_s2 <= d_s1;
			z_s2 <= z_s1;
		end
	end

	// Stage 3: back-multiply the estimate
	assign qd = {6'd0, q_s2} * {17'd0, d_s2};

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			qd_s3 <= qd;
			q_s3  <= q_s2;
			n_s3  <= n_s2;
			d_s3  <= d_s2;
			z_s3  <= z_s2;
		end
	end

	// Stage 4: correct by one where the remainder still covers the divisor
	assign rem = n_s3 - qd_s3[19:0];

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			if (z_s3) begin
				freq_s4 <= 17'd0;
			end else begin
				freq_s4 <= q_s3 + {16'd0, (rem >= {14'd0, d_s3})};
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/pfvp_volt_power.sv
// Voltage and power path: constant scaling, one product, per-code rescale.
`default_nettype none

module pfvp_volt_power (
	input  wire logic                clk,
	input  wire pfvp_pkg::stage_ld_t ld,
	input  wire logic [7:0]          voltage_id,
	input  wire logic [7:0]          idd_value,
	input  wire logic [1:0]          idd_divider,
	input  wire logic                keep_volt,
	input  wire logic                keep_pwr,
	output logic [20:0]              volt_s4,
	output logic [18:0]              pwr_s4
);
	import pfvp_pkg::*;

	logic [20:0] volt_d;
	logic [8:0]  vid_ofs;
	logic [16:0] m_d;
	logic [30:0] div5;
	logic [18:0] pwr_d;

	logic [20:0] volt_s1, volt_s2, volt_s3;
	logic [16:0] m_s1;
	logic [1:0]  div_s1;
	logic [18:0] pwr_s2, pwr_s3;

	// Stage 1: voltage and the reduced power product
	assign vid_ofs = {1'b0, voltage_id} + PWR_VID_OFFSET;
	assign volt_d  = VOLT_OFFSET_UV + ({13'd0, voltage_id} * VOLT_STEP_UV);
	assign m_d     = {8'd0, vid_ofs} * {9'd0, idd_value};

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			volt_s1 <= (keep_volt && (voltage_id != 8'd0)) ? volt_d : 21'd0;
			m_s1    <= (keep_pwr && (voltage_id != 8'd0)) ? m_d : 17'd0;
			div_s1  <= idd_divider;
		end
	end

	// Stage 2: apply the current scale (raw = 500*m)
	assign div5 = {16'd0, m_s1[16:2]} * RECIP_5;

	always_comb begin
		unique case (div_s1)
			IDD_DIV_100:   pwr_d = {m_s1, 2'b00} + {2'b00, m_s1};
			IDD_DIV_1000:  pwr_d = {3'd0, m_s1[16:1]};
			IDD_DIV_10000: pwr_d = {6'd0, div5[RECIP_5_SH+12:RECIP_5_SH]};
			IDD_DIV_BAD:   pwr_d = 19'd0;
			default:       pwr_d = 19'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			pwr_s2  <= pwr_d;
			volt_s2 <= volt_s1;
		end
	end

	// Stages 3 and 4: keep pace with the frequency divider
	always_ff @(posedge clk) begin
		if (ld.s3) begin
			pwr_s3  <= pwr_s2;
			volt_s3 <= volt_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			pwr_s4  <= pwr_s3;
			volt_s4 <= volt_s3;
		end
	end

endmodule

`default_nettype wire
